// ===== src/interleaved_address_decoder_assert.svh =====
// Assertion macros for the interleaved address decoder.
`ifndef INTERLEAVED_ADDRESS_DECODER_ASSERT_SVH
`define INTERLEAVED_ADDRESS_DECODER_ASSERT_SVH
// Implication checked every clock edge, off during reset.
`define IAD_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define IAD_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/iad_pkg.sv =====
// Shared types and constants for the interleaved address decoder.
`timescale 1ns / 1ps
package iad_pkg;
  localparam int NumTargets = 8;
  localparam int IdxW = 3;
  localparam logic [1:0] OUT_MATCH = 2'd0;
  localparam logic [1:0] OUT_DEFAULT = 2'd1;
  localparam logic [1:0] OUT_ZERO = 2'd2;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] limit;
    logic [31:0] stripe;
    logic [6:0]  ways;
    logic [5:0]  slice;
    logic [5:0]  shift;
    logic        xmode;
    logic        dflt;
  } entry_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
    logic [63:0] rem;
  } div_rsp_t;

  function automatic logic [63:0] shr_sat(input logic [63:0] v, input logic [6:0] n);
    shr_sat = (n >= 7'd64) ? 64'd0 : (v >> n[5:0]);
  endfunction
endpackage

// ===== src/iad_div.sv =====
// Shared radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "interleaved_address_decoder_assert.svh"
module iad_div (
  input  logic              clk,
  input  logic              rst_n,
  input  iad_pkg::div_req_t req,
  output iad_pkg::div_rsp_t rsp
);
  import iad_pkg::*;
  logic [63:0] q_r, q_nxt, d_r, d_nxt;
  logic [64:0] r_r, r_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [64:0] trial;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; r_nxt = r_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {r_r[63:0], q_r[63]};
    if (req.start) begin
      q_nxt = req.num; d_nxt = req.den; r_nxt = '0; cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt; d_r <= d_nxt; r_r <= r_nxt;
    if (!rst_n) begin
      cnt_r <= '0; busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = q_r;
  assign rsp.rem  = r_r[63:0];

  `IAD_ASSERT_NXT(a_done_pulse, clk, rst_n, done_r, !done_r)
  `IAD_ASSERT_IMP(a_done_idle, clk, rst_n, done_r, !busy_r)
  `IAD_ASSERT_NXT(a_start_busy, clk, rst_n, req.start, busy_r)
endmodule

// ===== src/interleaved_address_decoder.sv =====
// Interleaved address decoder top level: entry table and decode sequencer.
// Load: accepted while idle, no result. Decode: entries are scanned in order; a non-default
// in-range entry with ways > 1 adds two divider passes (stripe index, mod ways).
// One request at a time; the next is taken the cycle after the result handshake.
// Synchronous active-low reset clears control and active_targets; table undefined until loaded.
`timescale 1ns / 1ps
`include "interleaved_address_decoder_assert.svh"
module interleaved_address_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [3:0]   cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // entry_index, entry_base, entry_limit, entry_stripe, entry_ways, entry_slice,
  // entry_shift, entry_xor, entry_default, address; 248 bits
  input  logic [247:0] in_tdata,
  input  logic         in_tuser,   // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata    // target_index, outcome
);
  import iad_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_DIV1 = 6'b000100,
    S_DIV2 = 6'b001000, S_OUT  = 6'b010000, S_WAIT = 6'b100000
  } state_t;

  state_t      st_r, st_nxt;
  entry_t      tab_r [NumTargets];
  logic [3:0]  act_r;
  logic [63:0] addr_r, addr_nxt;
  logic [3:0]  i_r, i_nxt, n_lim;
  logic [IdxW-1:0] def_r, def_nxt, tgt_r, tgt_nxt;
  logic        hasdef_r, hasdef_nxt;
  logic [1:0]  oc_r, oc_nxt;
  logic        ovld_r;
  div_req_t    dreq;
  div_rsp_t    drsp;
  entry_t      cur, ld;
  logic [63:0] h;
  logic [6:0]  sh2;

  iad_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == S_IDLE);
  assign n_lim = (act_r > 4'(NumTargets)) ? 4'(NumTargets) : act_r;
  assign cur = tab_r[i_r[IdxW-1:0]];
  assign sh2 = {cur.shift, 1'b0};
  assign h = cur.xmode ? (drsp.quo ^ shr_sat(drsp.quo, {1'b0, cur.shift})
                                    ^ shr_sat(drsp.quo, sh2)) : drsp.quo;

  assign ld.base = in_tdata[66:3];
  assign ld.limit = in_tdata[130:67];
  assign ld.stripe = in_tdata[162:131];
  assign ld.ways = in_tdata[169:163];
  assign ld.slice = in_tdata[175:170];
  assign ld.shift = in_tdata[181:176];
  assign ld.xmode = in_tdata[182];
  assign ld.dflt = in_tdata[183];

  always_comb begin
    st_nxt = st_r; addr_nxt = addr_r; i_nxt = i_r; def_nxt = def_r;
    hasdef_nxt = hasdef_r; tgt_nxt = tgt_r; oc_nxt = oc_r;
    dreq = '0;
    case (st_r)
      S_IDLE: if (in_tvalid && in_tuser) begin
        addr_nxt = in_tdata[247:184]; i_nxt = '0; hasdef_nxt = 1'b0; st_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (i_r >= n_lim) begin
          tgt_nxt = hasdef_r ? def_r : '0;
          oc_nxt = hasdef_r ? OUT_DEFAULT : OUT_ZERO;
          st_nxt = S_OUT;
        end else if (cur.dflt) begin
          def_nxt = i_r[IdxW-1:0]; hasdef_nxt = 1'b1; i_nxt = i_r + 4'd1;
        end else if (!(addr_r >= cur.base && addr_r < cur.limit)) begin
          i_nxt = i_r + 4'd1;
        end else if (cur.ways <= 7'd1) begin
          tgt_nxt = i_r[IdxW-1:0]; oc_nxt = OUT_MATCH; st_nxt = S_OUT;
        end else begin
          dreq.start = 1'b1;
          dreq.num = addr_r - cur.base;
          dreq.den = (cur.stripe == '0) ? 64'd1 : {32'd0, cur.stripe};
          st_nxt = S_DIV1;
        end
      end
      S_DIV1: if (drsp.done) begin
        dreq.start = 1'b1; dreq.num = h; dreq.den = {57'd0, cur.ways}; st_nxt = S_DIV2;
      end
      S_DIV2: if (drsp.done) begin
        if (drsp.rem == {58'd0, cur.slice}) begin
          tgt_nxt = i_r[IdxW-1:0]; oc_nxt = OUT_MATCH; st_nxt = S_OUT;
        end else begin
          i_nxt = i_r + 4'd1; st_nxt = S_SCAN;
        end
      end
      S_OUT: st_nxt = S_WAIT;
      S_WAIT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; i_r <= i_nxt; def_r <= def_nxt; tgt_r <= tgt_nxt; oc_r <= oc_nxt;
    if (st_r == S_IDLE && in_tvalid && !in_tuser)
      tab_r[in_tdata[2:0]] <= ld;
    if (!rst_n) begin
      st_r <= S_IDLE; act_r <= '0; hasdef_r <= 1'b0; ovld_r <= 1'b0;
    end else begin
      st_r <= st_nxt; hasdef_r <= hasdef_nxt;
      if (cfg_valid) act_r <= cfg_data;
      ovld_r <= (st_nxt == S_WAIT);
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata = {3'd0, oc_r, tgt_r};

  `IAD_ASSERT_IMP(a_out_wait, clk, rst_n, out_tvalid, st_r == S_WAIT)
  `IAD_ASSERT_IMP(a_busy_noin, clk, rst_n, drsp.busy, !in_tready)
  `IAD_ASSERT_IMP(a_oc_valid, clk, rst_n, out_tvalid, oc_r <= OUT_ZERO)
endmodule

// ===== tb/sv/testbench.sv =====
// Testbench for the interleaved address decoder: table loads, decodes, checks.
`timescale 1ns / 1ps
module testbench;
  import iad_pkg::*;

  localparam bit ACT_LOAD = 1'b0;
  localparam bit ACT_DECODE = 1'b1;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_CYCLES = 1200;

  typedef struct packed {
    logic [2:0] target;
    logic [1:0] outcome;
  } route_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [3:0]   cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [247:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [7:0]   out_tdata;

  entry_t     table_shadow [NumTargets];
  logic [3:0] search_count = '0;
  route_t     pending_routes [$];
  int         mismatches = 0;
  int         cycles = 0;
  bit         quiet = 1'b0;

  interleaved_address_decoder i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[interleaved_address_decoder] ERROR");
      $finish;
    end
  end

  function automatic logic [63:0] fold(input logic [63:0] v, input int n);
    return (n >= 64) ? 64'd0 : (v >> n);
  endfunction

  function automatic bit entry_hits(input entry_t e, input logic [63:0] addr);
    logic [63:0] stripe, idx, h;
    if (!(addr >= e.base && addr < e.limit)) return 1'b0;
    if (e.ways <= 7'd1) return 1'b1;
    stripe = (e.stripe == 32'd0) ? 64'd1 : {32'd0, e.stripe};
    idx = (addr - e.base) / stripe;
    h = e.xmode ? (idx ^ fold(idx, int'(e.shift)) ^ fold(idx, 2 * int'(e.shift))) : idx;
    return (h % {57'd0, e.ways}) == {58'd0, e.slice};
  endfunction

  function automatic route_t route_address(input logic [63:0] addr);
    route_t r;
    int n;
    int dflt_idx;
    bit has_dflt;
    dflt_idx = 0;
    has_dflt = 1'b0;
    n = (search_count > NumTargets) ? NumTargets : search_count;
    for (int i = 0; i < n; i++) begin
      if (table_shadow[i].dflt) begin
        dflt_idx = i;
        has_dflt = 1'b1;
      end else if (entry_hits(table_shadow[i], addr)) begin
        r.target = i[2:0];
        r.outcome = OUT_MATCH;
        return r;
      end
    end
    r.target = has_dflt ? dflt_idx[2:0] : 3'd0;
    r.outcome = has_dflt ? OUT_DEFAULT : OUT_ZERO;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result checker: each result is compared with the oldest expected route.
  always @(posedge clk) begin
    route_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_routes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        exp_r = pending_routes.pop_front();
        if (out_tdata[2:0] !== exp_r.target || out_tdata[4:3] !== exp_r.outcome
            || out_tdata[7:5] !== 3'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("route mismatch: exp target %0d outcome %0d, got target %0d outcome %0d",
                     exp_r.target, exp_r.outcome, out_tdata[2:0], out_tdata[4:3]);
        end
      end
    end
  end

  // Receiver backpressure.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_tready = 1'b1;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_tready = 1'b0;
          repeat (n - 1) @(negedge clk);
          @(negedge clk);
        end
        out_tready = 1'b1;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  end

  task automatic send_request(input bit act, input logic [2:0] idx, input entry_t e,
                              input logic [63:0] addr);
    int gap;
    @(negedge clk);
    in_tuser = act;
    in_tdata = {addr, e.dflt, e.xmode, e.shift, e.slice, e.ways, e.stripe, e.limit,
                e.base, idx};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    if (act == ACT_LOAD) table_shadow[idx] = e;
    else pending_routes.push_back(route_address(addr));
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_routes.size() == 0);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_search_count(input logic [3:0] v);
    wait_idle();
    cfg_data = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    search_count = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic entry_t mk_entry(input logic [63:0] base, input logic [63:0] limit,
                                      input logic [31:0] stripe, input logic [6:0] ways,
                                      input logic [5:0] slice, input logic [5:0] shift,
                                      input logic xmode, input logic dflt);
    entry_t e;
    e = '{base, limit, stripe, ways, slice, shift, xmode, dflt};
    return e;
  endfunction

  function automatic entry_t rand_entry();
    entry_t e;
    logic [63:0] span;
    int r;
    r = $urandom_range(0, 9);
    e.base = (r == 0) ? 64'd0 : (r == 1) ? {$urandom, $urandom} | 64'hFFFF_FFFF_FFFF_0000
           : {$urandom, $urandom};
    span = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
         : 64'($urandom_range(1, 1 << 16));
    e.limit = ($urandom_range(0, 11) == 0) ? e.base - 64'($urandom_range(0, 3))
            : e.base + span;
    r = $urandom_range(0, 9);
    e.stripe = (r == 0) ? 32'd0 : (r < 3) ? $urandom : $urandom_range(1, 256);
    r = $urandom_range(0, 9);
    e.ways = (r < 2) ? 7'($urandom_range(0, 1)) : (r < 8) ? 7'($urandom_range(2, 8))
           : 7'($urandom_range(9, 127));
    e.slice = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
            : 6'($urandom_range(0, (e.ways > 1) ? ((e.ways > 64) ? 63 : e.ways - 1) : 0));
    e.shift = 6'($urandom_range(0, 63));
    e.xmode = 1'($urandom_range(0, 1));
    e.dflt = ($urandom_range(0, 5) == 0);
    return e;
  endfunction

  function automatic logic [63:0] rand_address();
    entry_t e;
    logic [63:0] span;
    if ($urandom_range(0, 4) == 0) return {$urandom, $urandom};
    e = table_shadow[3'($urandom_range(0, NumTargets - 1))];
    span = e.limit - e.base;
    if (span == 0 || $urandom_range(0, 9) == 0)
      return e.limit - 64'd1 + 64'($urandom_range(0, 2));
    return e.base + (({$urandom, $urandom}) % span);
  endfunction

  task automatic test_empty_search();
    entry_t z;
    z = '0;
    write_search_count(4'd0);
    send_request(ACT_DECODE, 3'd0, z, 64'd0);
    send_request(ACT_DECODE, 3'd0, z, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_table_load();
    send_request(ACT_LOAD, 3'd0, mk_entry(64'h1000, 64'h2000, 32'd0, 7'd0, 6'd0, 6'd0,
                 1'b0, 1'b0), '0);
    send_request(ACT_LOAD, 3'd1, mk_entry(64'h0, 64'h0, 32'd1, 7'd1, 6'd0, 6'd0,
                 1'b0, 1'b1), '0);
    send_request(ACT_LOAD, 3'd2, mk_entry(64'h4000, 64'h3000, 32'd16, 7'd0, 6'd0, 6'd0,
                 1'b0, 1'b0), '0);
    send_request(ACT_LOAD, 3'd3, mk_entry(64'h10000, 64'h20000, 32'h40, 7'd4, 6'd2, 6'd0,
                 1'b0, 1'b0), '0);
    send_request(ACT_LOAD, 3'd4, mk_entry(64'h10000, 64'h20000, 32'h40, 7'd4, 6'd3, 6'd63,
                 1'b1, 1'b0), '0);
    send_request(ACT_LOAD, 3'd5, mk_entry(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                 7'd64, 6'd63, 6'd1, 1'b1, 1'b0), '0);
    send_request(ACT_LOAD, 3'd6, mk_entry(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_FFFF,
                 32'd0, 7'd127, 6'd5, 6'd32, 1'b1, 1'b1), '0);
    send_request(ACT_LOAD, 3'd7, mk_entry(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd3, 7'd1,
                 6'd0, 6'd0, 1'b0, 1'b0), '0);
  endtask

  task automatic test_directed_decode();
    entry_t z;
    z = '0;
    write_search_count(4'd15);  // saturates to the table size
    send_request(ACT_DECODE, 3'd0, z, 64'h1000);
    send_request(ACT_DECODE, 3'd0, z, 64'h1FFF);
    send_request(ACT_DECODE, 3'd0, z, 64'h2000);
    send_request(ACT_DECODE, 3'd0, z, 64'h3800);
    send_request(ACT_DECODE, 3'd0, z, 64'h10080);
    send_request(ACT_DECODE, 3'd0, z, 64'h100C0);
    send_request(ACT_DECODE, 3'd0, z, 64'h0);
    send_request(ACT_DECODE, 3'd0, z, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ACT_DECODE, 3'd0, z, 64'hFFFF_FFFF_FFFF_F800);
    write_search_count(4'd1);
    send_request(ACT_DECODE, 3'd0, z, 64'h5);
    write_search_count(4'd3);
    send_request(ACT_DECODE, 3'd0, z, 64'h5);
    write_search_count(4'd8);
    send_request(ACT_DECODE, 3'd0, z, 64'h10040);
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 1000; i++) begin
      if (i % 125 == 0) begin
        quiet = (i == 250);
        write_search_count(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                           : 4'($urandom_range(6, 8)));
      end
      // hold off once until everything has come back
      if (i == 500) wait_idle();
      if ($urandom_range(0, 3) == 0)
        send_request(ACT_LOAD, 3'($urandom_range(0, 7)), rand_entry(),
                     {$urandom, $urandom});
      else
        send_request(ACT_DECODE, 3'($urandom),
                     entry_t'(184'({$urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom})), rand_address());
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_empty_search();
    test_table_load();
    test_directed_decode();
    test_random_traffic();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (pending_routes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_routes.size() == 0) begin
      $display("[interleaved_address_decoder] OK");
    end else begin
      $display("[interleaved_address_decoder] ERROR");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+src
src/iad_pkg.sv
src/iad_div.sv
src/interleaved_address_decoder.sv
tb/sv/testbench.sv
